// File: hw/rtl/zsbf_pkg.sv
package zsbf_pkg;

    localparam logic [31:0] BLOCK_BYTES = 32'd65535;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF    = 8'h78;
    localparam logic [7:0]  ZLIB_FLG    = 8'h01;
    localparam logic [7:0]  BFLAG_FINAL = 8'h01;
    localparam logic [7:0]  BFLAG_MORE  = 8'h00;
    localparam logic [7:0]  STRAY_BYTE  = 8'h00;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_DATA,
        CMD_STRAY
    } t_cmd_kind;

    typedef enum logic [3:0] {
        PH_START,
        PH_ZHDR0,
        PH_ZHDR1,
        PH_BFLAG,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_NLEN_LO,
        PH_NLEN_HI,
        PH_DATA,
        PH_ADL0,
        PH_ADL1,
        PH_ADL2,
        PH_ADL3,
        PH_STRAY
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
        logic       stray_error;
    } t_out_word;

    // One entry of the queue: everything the back end needs to emit the bytes of one item.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data_byte;
        logic        hdr;
        logic        final_blk;
        logic [15:0] len;
        logic        trailer;
        logic [15:0] sum_high;
        logic [15:0] sum_low;
    } t_cmd;

    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_status;

endpackage

// File: hw/rtl/zsbf_front.sv
module zsbf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_in_valid,
    input  zsbf_pkg::t_in_word i_in_word,
    input  logic             i_q_full,
    output logic             o_push,
    output zsbf_pkg::t_cmd   o_cmd
);
    import zsbf_pkg::*;

    logic [31:0] r_total_length;
    logic [15:0] r_sum_low, n_sum_low;
    logic [15:0] r_sum_high, n_sum_high;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_block_left, n_block_left;
    logic        r_stream_open, n_stream_open;

    logic [16:0] low_add, low_red, high_add, high_red;
    logic [31:0] left_dec, hdr_src;
    logic [15:0] blk_dec;
    logic [15:0] hdr_len;
    logic        hdr_final;

    assign o_push = i_in_valid && !i_q_full;

    assign left_dec = r_bytes_left - 32'd1;
    assign blk_dec  = r_block_left - 16'd1;

    // Adler-32 update, reduced after each byte.
    always_comb begin
        low_add  = {1'b0, r_sum_low} + {9'd0, i_in_word.data_byte};
        low_red  = (low_add >= ADLER_MOD) ? low_add - ADLER_MOD : low_add;
        high_add = {1'b0, r_sum_high} + low_red;
        high_red = (high_add >= ADLER_MOD) ? high_add - ADLER_MOD : high_add;
    end

    // The next block covers what is left, up to the block size.
    always_comb begin
        hdr_src   = i_in_word.func ? left_dec : r_total_length;
        hdr_final = (hdr_src <= BLOCK_BYTES);
        hdr_len   = hdr_final ? hdr_src[15:0] : BLOCK_BYTES[15:0];
    end

    always_comb begin
        n_sum_low     = r_sum_low;
        n_sum_high    = r_sum_high;
        n_bytes_left  = r_bytes_left;
        n_block_left  = r_block_left;
        n_stream_open = r_stream_open;
        o_cmd           = '0;
        o_cmd.kind      = CMD_STRAY;
        o_cmd.data_byte = i_in_word.data_byte;
        o_cmd.final_blk = hdr_final;
        o_cmd.len       = hdr_len;
        if (!i_in_word.func) begin
            n_sum_low      = 16'd1;
            n_sum_high     = 16'd0;
            n_bytes_left   = r_total_length;
            n_block_left   = hdr_len;
            n_stream_open  = (r_total_length != 32'd0);
            o_cmd.kind     = CMD_BEGIN;
            o_cmd.hdr      = 1'b1;
            o_cmd.trailer  = (r_total_length == 32'd0);
            o_cmd.sum_high = 16'd0;
            o_cmd.sum_low  = 16'd1;
        end else if (r_stream_open && (r_bytes_left != 32'd0)) begin
            n_sum_low      = low_red[15:0];
            n_sum_high     = high_red[15:0];
            n_bytes_left   = left_dec;
            o_cmd.kind     = CMD_DATA;
            o_cmd.trailer  = (left_dec == 32'd0);
            o_cmd.hdr      = (left_dec != 32'd0) && (blk_dec == 16'd0);
            o_cmd.sum_high = high_red[15:0];
            o_cmd.sum_low  = low_red[15:0];
            n_block_left   = o_cmd.hdr ? hdr_len : blk_dec;
            if (left_dec == 32'd0) begin
                n_stream_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= '0;
            r_sum_low      <= 16'd1;
            r_sum_high     <= '0;
            r_bytes_left   <= '0;
            r_block_left   <= '0;
            r_stream_open  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_total_length <= i_cfg_data;
            end
            if (o_push) begin
                r_sum_low     <= n_sum_low;
                r_sum_high    <= n_sum_high;
                r_bytes_left  <= n_bytes_left;
                r_block_left  <= n_block_left;
                r_stream_open <= n_stream_open;
            end
        end
    end

endmodule

// File: hw/rtl/zsbf_queue.sv
module zsbf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  zsbf_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output zsbf_pkg::t_cmd      o_head,
    output zsbf_pkg::t_q_status o_status
);
    import zsbf_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_head            = r_mem[r_rd_ptr];
    assign o_status.head_valid = (r_count != '0);
    assign o_status.full       = (r_count == Q_CNT_W'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/zsbf_back.sv
module zsbf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zsbf_pkg::t_cmd      i_head,
    input  zsbf_pkg::t_q_status i_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output zsbf_pkg::t_out_word o_out_word
);
    import zsbf_pkg::*;

    t_phase    r_phase, n_phase;
    t_phase    cur;
    t_out_word r_out, n_out;
    logic      r_out_valid;
    logic      load_en, fire, done;
    logic [15:0] nlen;

    assign load_en = !r_out_valid || !i_out_stall;
    assign fire    = load_en && i_status.head_valid;
    assign o_pop   = fire && done;
    assign nlen    = ~i_head.len;

    always_comb begin
        if (r_phase == PH_START) begin
            unique case (i_head.kind)
                CMD_BEGIN: cur = PH_ZHDR0;
                CMD_DATA:  cur = PH_DATA;
                default:   cur = PH_STRAY;
            endcase
        end else begin
            cur = r_phase;
        end
    end

    always_comb begin
        n_out = '0;
        done  = 1'b0;
        n_phase = r_phase;
        unique case (cur)
            PH_ZHDR0: begin
                n_out.out_byte = ZLIB_CMF;
                n_phase = PH_ZHDR1;
            end
            PH_ZHDR1: begin
                n_out.out_byte = ZLIB_FLG;
                n_phase = PH_BFLAG;
            end
            PH_BFLAG: begin
                n_out.out_byte = i_head.final_blk ? BFLAG_FINAL : BFLAG_MORE;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_out.out_byte = i_head.len[7:0];
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_out.out_byte = i_head.len[15:8];
                n_phase = PH_NLEN_LO;
            end
            PH_NLEN_LO: begin
                n_out.out_byte = nlen[7:0];
                n_phase = PH_NLEN_HI;
            end
            PH_NLEN_HI: begin
                n_out.out_byte = nlen[15:8];
                n_phase = i_head.trailer ? PH_ADL0 : PH_START;
                done = !i_head.trailer;
            end
            PH_DATA: begin
                n_out.out_byte = i_head.data_byte;
                if (i_head.trailer) begin
                    n_phase = PH_ADL0;
                end else if (i_head.hdr) begin
                    n_phase = PH_BFLAG;
                end else begin
                    n_phase = PH_START;
                    done = 1'b1;
                end
            end
            PH_ADL0: begin
                n_out.out_byte = i_head.sum_high[15:8];
                n_phase = PH_ADL1;
            end
            PH_ADL1: begin
                n_out.out_byte = i_head.sum_high[7:0];
                n_phase = PH_ADL2;
            end
            PH_ADL2: begin
                n_out.out_byte = i_head.sum_low[15:8];
                n_phase = PH_ADL3;
            end
            PH_ADL3: begin
                n_out.out_byte = i_head.sum_low[7:0];
                n_out.stream_done = 1'b1;
                n_phase = PH_START;
                done = 1'b1;
            end
            PH_STRAY: begin
                n_out.out_byte = STRAY_BYTE;
                n_out.stray_error = 1'b1;
                n_phase = PH_START;
                done = 1'b1;
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
        n_out.last_of_run = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_out_valid <= 1'b0;
        end else if (load_en) begin
            r_out_valid <= i_status.head_valid;
            if (fire) begin
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// File: hw/rtl/zlib_stored_block_framer.sv
// Channel   Direction  Handshake                Payload
// cfg       in         i_cfg_valid/o_cfg_ready  i_cfg_data (total_length)
// in        in         i_in_valid/o_in_stall    i_in_word (func, data_byte)
// out       out        o_out_valid/i_out_stall  o_out_word (out_byte and flags)
//
// The front end takes one item per cycle while its four-entry queue has room.
// The back end emits one word per cycle while the output is not stalled: a
// begin item gives the zlib header, block flag, LEN and NLEN; a payload byte
// gives itself, and at a block boundary a new block flag, LEN and NLEN; the
// trailer adds the Adler-32 sum, high half first. Output words come from a
// register, loaded from the head of the queue when the output is not stalled.
// Reset is synchronous and empties the queue, which decouples the two stalls.
module zlib_stored_block_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  zsbf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output zsbf_pkg::t_out_word o_out_word
);
    import zsbf_pkg::*;

    logic      push, pop;
    t_cmd      cmd, head;
    t_q_status status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = status.full;

    zsbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_q_full    (status.full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    zsbf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    zsbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
